// File: hdl/mmle_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and field helpers for the multilinear extension evaluator.
// No dependencies; every other file except mmle_ram imports this package.
package mmle_pkg;

	// Field modulus, 2^31 - 1
	localparam logic [30:0] FIELD_P = 31'h7FFF_FFFF;

	localparam int DIM_W       = 5;  // width of the dimension registers
	localparam int BITS_W      = 3;  // holds a bit count of 1..5
	localparam int COORD_DEPTH = 8;
	localparam int COORD_AW    = 3;
	localparam int POS_W       = 4;  // coordinate position, may run past the store

	// Item opcodes
	localparam logic [1:0] OP_WRITE_ENTRY = 2'd0;
	localparam logic [1:0] OP_WRITE_COORD = 2'd1;
	localparam logic [1:0] OP_EVAL        = 2'd2;

	// Register indexes, decoded from paddr[2]
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] num_rows;
		logic [DIM_W-1:0] num_cols;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [30:0] a;
		logic [30:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] y;
	} mul_rsp_t;

	// Reduce a 31-bit input into 0..P-1; only P itself is out of range
	function automatic logic [30:0] fold_in(input logic [30:0] v);
		return (v == FIELD_P) ? 31'd0 : v;
	endfunction

	// Index bits for a dimension: ceil(log2(n)), at least 1
	function automatic logic [BITS_W-1:0] bit_count(input logic [DIM_W-1:0] n);
		logic [BITS_W-1:0] b;
		if (n <= 5'd2) b = 3'd1;
		else if (n <= 5'd4) b = 3'd2;
		else if (n <= 5'd8) b = 3'd3;
		else if (n <= 5'd16) b = 3'd4;
		else b = 3'd5;
		return b;
	endfunction

endpackage

// File: hdl/mmle_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mmle_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/mmle_fmul.sv
`timescale 1ns / 1ps
// Two-stage modular multiplier mod 2^31-1: raw product, then Mersenne fold.
// Depends on mmle_pkg.
module mmle_fmul import mmle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [61:0] prod_s1;
	logic        vld_s1;
	logic [30:0] y_s2;
	logic        vld_s2;
	logic [31:0] fold_sum;

	// Fold high half onto low half; sum stays below 2P
	assign fold_sum = {1'b0, prod_s1[30:0]} + {1'b0, prod_s1[61:31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		prod_s1 <= {31'd0, req.a} * {31'd0, req.b};
		y_s2    <= (fold_sum >= {1'b0, FIELD_P}) ? 31'(fold_sum - {1'b0, FIELD_P})
		                                         : fold_sum[30:0];
	end

	assign rsp.done = vld_s2;
	assign rsp.y    = y_s2;

endmodule

// File: hdl/mmle_eval.sv
`timescale 1ns / 1ps
// Item decode and evaluation sequencer: drives both store RAMs and the shared multiplier.
// Depends on mmle_pkg.
module mmle_eval import mmle_pkg::*; #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16,
	localparam int MAT_AW = $clog2(MAX_ROWS * MAX_COLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [3:0]          row_index,
	input  logic [3:0]          col_index,
	input  logic [30:0]         entry_value,
	input  logic [2:0]          coord_index,
	input  logic [30:0]         coord_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [30:0]         mle_value,
	output logic                mat_we,
	output logic [MAT_AW-1:0]   mat_waddr,
	output logic [30:0]         mat_wdata,
	output logic [MAT_AW-1:0]   mat_raddr,
	input  logic [30:0]         mat_rdata,
	output logic                crd_we,
	output logic [COORD_AW-1:0] crd_waddr,
	output logic [30:0]         crd_wdata,
	output logic [COORD_AW-1:0] crd_raddr,
	input  logic [30:0]         crd_rdata,
	output mul_req_t            mul_req,
	input  mul_rsp_t            mul_rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_TERM,
		S_TWAIT,
		S_MAT,
		S_MWAIT,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [DIM_W-1:0]  rows_q, cols_q, r_q, c_q;
	logic [BITS_W-1:0] rb_q, cb_q, k_q;
	logic              row_phase_q;
	logic [30:0]       rf_q, cf_q, sum_q, out_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  rd_pos_q;

	logic              accept;
	logic [DIM_W-1:0]  rows_clamp, cols_clamp;
	logic [16:0]       waddr_full, raddr_full;
	logic [POS_W-1:0]  cpos;
	logic [30:0]       x_val, term;
	logic [31:0]       inv_tmp;
	logic              term_bit;
	logic [31:0]       add_sum;
	logic [30:0]       add_res;
	logic              out_free;
	logic              more_cols, more_rows;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// Saturate the dimension registers into 1..MAX
	always_comb begin
		if (cfg.num_rows == '0) rows_clamp = 5'd1;
		else if (9'(cfg.num_rows) > 9'(MAX_ROWS)) rows_clamp = 5'(MAX_ROWS);
		else rows_clamp = cfg.num_rows;
		if (cfg.num_cols == '0) cols_clamp = 5'd1;
		else if (9'(cfg.num_cols) > 9'(MAX_COLS)) cols_clamp = 5'(MAX_COLS);
		else cols_clamp = cfg.num_cols;
	end

	// Store writes straight from the accepted beat
	assign waddr_full = 17'(row_index) * 17'(MAX_COLS) + 17'(col_index);
	assign mat_we     = accept && (opcode == OP_WRITE_ENTRY)
	                    && (9'(row_index) < 9'(MAX_ROWS)) && (9'(col_index) < 9'(MAX_COLS));
	assign mat_waddr  = waddr_full[MAT_AW-1:0];
	assign mat_wdata  = fold_in(entry_value);
	assign crd_we     = accept && (opcode == OP_WRITE_COORD);
	assign crd_waddr  = coord_index;
	assign crd_wdata  = fold_in(coord_value);

	// Matrix read follows the current cell
	assign raddr_full = 17'(r_q) * 17'(MAX_COLS) + 17'(c_q);
	assign mat_raddr  = raddr_full[MAT_AW-1:0];

	assign more_cols = (6'(c_q) + 6'd1) < 6'(cols_q);
	assign more_rows = (6'(r_q) + 6'd1) < 6'(rows_q);

	// Coordinate position for the term needed next
	always_comb begin
		unique case (state_q)
			S_START: cpos = '0;
			S_TWAIT: cpos = row_phase_q ? (4'(k_q) + 4'd1) : (4'(rb_q) + 4'(k_q) + 4'd1);
			S_MWAIT: cpos = more_cols ? 4'(rb_q) : '0;
			default: cpos = rd_pos_q;
		endcase
	end
	assign crd_raddr = cpos[COORD_AW-1:0];

	// Eq term: x when the index bit is set, else 1 - x mod P
	assign x_val    = (rd_pos_q >= 4'(COORD_DEPTH)) ? 31'd0 : crd_rdata;
	assign inv_tmp  = {1'b0, FIELD_P} + 32'd1 - {1'b0, x_val};
	assign term_bit = row_phase_q ? r_q[k_q] : c_q[k_q];
	assign term     = term_bit ? x_val
	                : ((inv_tmp >= {1'b0, FIELD_P}) ? 31'(inv_tmp - {1'b0, FIELD_P})
	                                                : inv_tmp[30:0]);

	// Multiplier request
	always_comb begin
		mul_req.start = (state_q == S_TERM) || (state_q == S_MAT);
		mul_req.a     = (state_q == S_TERM && row_phase_q) ? rf_q : cf_q;
		mul_req.b     = (state_q == S_MAT) ? mat_rdata : term;
	end

	// Running sum
	assign add_sum = {1'b0, sum_q} + {1'b0, mul_rsp.y};
	assign add_res = (add_sum >= {1'b0, FIELD_P}) ? 31'(add_sum - {1'b0, FIELD_P})
	                                               : add_sum[30:0];

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= '0;
			cols_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			rb_q        <= '0;
			cb_q        <= '0;
			k_q         <= '0;
			row_phase_q <= 1'b0;
			rf_q        <= '0;
			cf_q        <= '0;
			sum_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			rd_pos_q    <= '0;
		end else begin
			rd_pos_q <= cpos;
			// drop a result once taken, unless a new one loads in its place
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_EVAL) begin
						rows_q      <= rows_clamp;
						cols_q      <= cols_clamp;
						rb_q        <= bit_count(rows_clamp);
						cb_q        <= bit_count(cols_clamp);
						r_q         <= '0;
						c_q         <= '0;
						k_q         <= '0;
						row_phase_q <= 1'b1;
						rf_q        <= 31'd1;
						sum_q       <= '0;
						state_q     <= S_START;
					end
				end
				S_START: begin
					state_q <= S_TERM;
				end
				S_TERM: begin
					state_q <= S_TWAIT;
				end
				S_TWAIT: begin
					if (mul_rsp.done) begin
						cf_q <= mul_rsp.y;
						if (row_phase_q) begin
							rf_q <= mul_rsp.y;
							if (k_q + 3'd1 == rb_q) begin
								row_phase_q <= 1'b0;
								k_q         <= '0;
							end else begin
								k_q <= k_q + 3'd1;
							end
							state_q <= S_TERM;
						end else if (k_q + 3'd1 == cb_q) begin
							k_q     <= '0;
							state_q <= S_MAT;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= S_TERM;
						end
					end
				end
				S_MAT: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mul_rsp.done) begin
						sum_q <= add_res;
						k_q   <= '0;
						if (more_cols) begin
							c_q     <= c_q + 5'd1;
							cf_q    <= rf_q;
							state_q <= S_TERM;
						end else if (more_rows) begin
							c_q         <= '0;
							r_q         <= r_q + 5'd1;
							rf_q        <= 31'd1;
							row_phase_q <= 1'b1;
							state_q     <= S_TERM;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q       <= sum_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign mle_value = out_q;

endmodule

// File: hdl/matrix_multilinear_extension_eval.sv
`timescale 1ns / 1ps
// Top level of the multilinear extension evaluator: register port, stores, multiplier, sequencer.
// Depends on mmle_pkg, mmle_ram, mmle_fmul and mmle_eval.
//
// Evaluates the multilinear extension of a stored matrix at a stored point over GF(2^31-1).
// Entry and coordinate writes produce no result. An evaluation walks every in-range cell
// on one shared two-stage multiplier. No item is taken during an evaluation; the result
// sits in an output register, so writes are taken while it waits to be read. Both stores
// come up undefined and need no clearing pass.
module matrix_multilinear_extension_eval import mmle_pkg::*; #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic [30:0] entry_value,
	input  logic [2:0]  coord_index,
	input  logic [30:0] coord_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] mle_value
);

	localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);

	cfg_t                cfg_q;
	logic                cfg_wr;
	mul_req_t            mul_req;
	mul_rsp_t            mul_rsp;
	logic                mat_we;
	logic [MAT_AW-1:0]   mat_waddr, mat_raddr;
	logic [30:0]         mat_wdata, mat_rdata;
	logic                crd_we;
	logic [COORD_AW-1:0] crd_waddr, crd_raddr;
	logic [30:0]         crd_wdata, crd_rdata;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_rows <= 5'd16;
			cfg_q.num_cols <= 5'd16;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_NUM_ROWS: cfg_q.num_rows <= pwdata[DIM_W-1:0];
				REG_NUM_COLS: cfg_q.num_cols <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NUM_ROWS: prdata = {27'd0, cfg_q.num_rows};
			REG_NUM_COLS: prdata = {27'd0, cfg_q.num_cols};
			default:      prdata = '0;
		endcase
	end

	// Matrix store
	mmle_ram #(.WIDTH(31), .DEPTH(MAT_DEPTH)) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	// Point coordinate store
	mmle_ram #(.WIDTH(31), .DEPTH(COORD_DEPTH)) u_crd_ram (
		.clk   (clk),
		.we    (crd_we),
		.waddr (crd_waddr),
		.wdata (crd_wdata),
		.raddr (crd_raddr),
		.rdata (crd_rdata)
	);

	mmle_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mmle_eval #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.row_index   (row_index),
		.col_index   (col_index),
		.entry_value (entry_value),
		.coord_index (coord_index),
		.coord_value (coord_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mle_value   (mle_value),
		.mat_we      (mat_we),
		.mat_waddr   (mat_waddr),
		.mat_wdata   (mat_wdata),
		.mat_raddr   (mat_raddr),
		.mat_rdata   (mat_rdata),
		.crd_we      (crd_we),
		.crd_waddr   (crd_waddr),
		.crd_wdata   (crd_wdata),
		.crd_raddr   (crd_raddr),
		.crd_rdata   (crd_rdata),
		.mul_req     (mul_req),
		.mul_rsp     (mul_rsp)
	);

	// A multiply result always comes from a request that passed through both multiplier stages
	a_mul_latency: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> $past(mul_req.start, 2))
		else $error("multiplier result without matching request");

	// No multiply is issued while items are being taken
	a_idle_no_mul: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !mul_req.start)
		else $error("multiply issued while idle");

	// A new result is only produced at the end of an evaluation
	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised outside an evaluation");

	// Results are fully reduced
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mle_value != FIELD_P))
		else $error("result not reduced mod P");

endmodule

// File: dv/mmle_mle_checker.sv
`timescale 1ns / 1ps
// Checker for the multilinear extension evaluator: follows the register port and both item
// channels, predicts every evaluation over GF(2^31-1) and compares each result beat in order.
// Depends on mmle_pkg.
module mmle_mle_checker import mmle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic [30:0] entry_value,
	input  logic [2:0]  coord_index,
	input  logic [30:0] coord_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [30:0] mle_value,
	output int          fail_count,
	output int          pending
);

	localparam int ROWS_MAX = 16;
	localparam int COLS_MAX = 16;

	cfg_t        dims;
	logic [30:0] cell_val [ROWS_MAX][COLS_MAX];
	logic [30:0] coord_val [COORD_DEPTH];
	logic [30:0] expected_mle [$];
	int          errs;

	// Bring a raw 31-bit value into 0..P-1
	function automatic logic [30:0] to_field(input logic [30:0] v);
		logic [31:0] wide;
		wide = {1'b0, v} % {1'b0, FIELD_P};
		return wide[30:0];
	endfunction

	function automatic logic [30:0] field_mul(input logic [30:0] a, input logic [30:0] b);
		logic [63:0] prod;
		prod = ({33'd0, a} * {33'd0, b}) % {33'd0, FIELD_P};
		return prod[30:0];
	endfunction

	function automatic logic [30:0] field_add(input logic [30:0] a, input logic [30:0] b);
		logic [31:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, FIELD_P})
			sum = sum - {1'b0, FIELD_P};
		return sum[30:0];
	endfunction

	// Product of x or (1 - x) over the index bits, LSB first, from coordinate base
	function automatic logic [30:0] eq_weight(input int idx, input int nbits, input int base);
		logic [30:0] acc;
		logic [30:0] x;
		logic [31:0] one_minus;
		acc = 31'd1;
		for (int k = 0; k < nbits; k++) begin
			x = (base + k < COORD_DEPTH) ? coord_val[base + k] : 31'd0;
			one_minus = ({1'b0, FIELD_P} + 32'd1 - {1'b0, x}) % {1'b0, FIELD_P};
			acc = field_mul(acc, ((idx >> k) & 1) ? x : one_minus[30:0]);
		end
		return acc;
	endfunction

	function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	// Weighted sum of the in-range cells at the stored point
	function automatic logic [30:0] mle_at_point();
		int rows;
		int cols;
		int rb;
		int cb;
		logic [30:0] acc;
		logic [30:0] row_w;
		rows = clamp_dim(dims.num_rows, ROWS_MAX);
		cols = clamp_dim(dims.num_cols, COLS_MAX);
		rb = 1;
		while ((1 << rb) < rows)
			rb++;
		cb = 1;
		while ((1 << cb) < cols)
			cb++;
		acc = 31'd0;
		for (int r = 0; r < rows; r++) begin
			row_w = eq_weight(r, rb, 0);
			for (int c = 0; c < cols; c++)
				acc = field_add(acc, field_mul(cell_val[r][c],
					field_mul(row_w, eq_weight(c, cb, rb))));
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] reg_now;
		logic [30:0] want;
		if (!arst_n) begin
			dims.num_rows = 5'd16;
			dims.num_cols = 5'd16;
			expected_mle.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Track register writes, check read data
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_NUM_ROWS)
						dims.num_rows = pwdata[DIM_W-1:0];
					else
						dims.num_cols = pwdata[DIM_W-1:0];
				end else begin
					reg_now = (paddr[2] == REG_NUM_ROWS) ? 32'(dims.num_rows) :
						32'(dims.num_cols);
					if (prdata !== reg_now) begin
						errs++;
						$display("%0t: register %0d read expected %0d, actual %0d",
							$time, paddr[2], reg_now, prdata);
					end
				end
			end

			// Match a result beat against the oldest evaluation
			if (out_valid && !out_stall) begin
				if (expected_mle.size() == 0) begin
					errs++;
					$display("%0t: mle_value expected none, actual %0d", $time, mle_value);
				end else begin
					want = expected_mle.pop_front();
					if (mle_value !== want) begin
						errs++;
						$display("%0t: mle_value expected %0d, actual %0d",
							$time, want, mle_value);
					end
				end
			end

			// Apply an input beat to the predicted state
			if (in_valid && !in_stall) begin
				case (opcode)
					OP_WRITE_ENTRY: cell_val[row_index][col_index] = to_field(entry_value);
					OP_WRITE_COORD: coord_val[coord_index] = to_field(coord_value);
					OP_EVAL: expected_mle = {expected_mle, mle_at_point()};
					default: ;
				endcase
			end

			fail_count <= errs;
			pending <= expected_mle.size();
		end
	end

endmodule

// File: dv/tb_matrix_multilinear_extension_eval.sv
`timescale 1ns / 1ps
// Testbench top for the multilinear extension evaluator: clock, reset, register setup,
// item and result pacing, watchdog, verdict. Uses mmle_pkg, the DUT and mmle_mle_checker.
module tb_matrix_multilinear_extension_eval;
	import mmle_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         NUM_PHASES  = 8;
	localparam int         PHASE_BEATS = 28;
	localparam int         STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [3:0]  row_index;
	logic [3:0]  col_index;
	logic [30:0] entry_value;
	logic [2:0]  coord_index;
	logic [30:0] coord_value;
	logic        out_valid;
	logic        out_stall;
	logic [30:0] mle_value;

	int mismatches;
	int mle_outstanding;

	bit calm;
	int hold_req;
	int idle_cycles;
	int beats_sent;
	int eff_rows;
	int eff_cols;
	int rb_cnt;
	int cb_cnt;
	bit cell_set [16][16];
	bit coord_set [COORD_DEPTH];

	// Register settings per phase, out-of-range values included
	int phase_rows [NUM_PHASES] = '{1, 16, 0, 5, 3, 9, 17, 9};
	int phase_cols [NUM_PHASES] = '{16, 1, 7, 3, 31, 0, 4, 9};

	matrix_multilinear_extension_eval u_top (.*);

	mmle_mle_checker u_chk (.*, .fail_count(mismatches), .pending(mle_outstanding));

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// End the run if no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stall bursts, long holds on request, none in the tail
	initial begin : sink_pacing
		int hold_left;
		int run_left;
		bit stalling;
		hold_left = 0;
		run_left = 0;
		stalling = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stalling = !stalling;
					run_left = stalling ? $urandom_range(1, 14) : $urandom_range(1, 40);
				end
				out_stall <= stalling;
				run_left--;
			end
		end
	end

	function automatic logic [30:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 31'd0;
			1: return 31'd1;
			2: return FIELD_P;
			3: return FIELD_P - 31'd1;
			default: return 31'($urandom);
		endcase
	endfunction

	// Offer one beat, possibly after a random gap, and hold it until taken
	task automatic drive_beat(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
			input logic [30:0] ev, input logic [2:0] ci, input logic [30:0] cv);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		row_index <= r;
		col_index <= c;
		entry_value <= ev;
		coord_index <= ci;
		coord_value <= cv;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic put_cell(input logic [3:0] r, input logic [3:0] c, input logic [30:0] v);
		drive_beat(OP_WRITE_ENTRY, r, c, v, 3'($urandom), 31'($urandom));
		cell_set[r][c] = 1'b1;
		beats_sent++;
	endtask

	task automatic put_coord(input logic [2:0] i, input logic [30:0] v);
		drive_beat(OP_WRITE_COORD, 4'($urandom), 4'($urandom), 31'($urandom), i, v);
		coord_set[i] = 1'b1;
		beats_sent++;
	endtask

	// Write whatever the evaluation would read that is still unwritten, then evaluate
	task automatic request_eval();
		for (int r = 0; r < eff_rows; r++)
			for (int c = 0; c < eff_cols; c++)
				if (!cell_set[r][c])
					put_cell(4'(r), 4'(c), pick_value());
		for (int i = 0; i < rb_cnt + cb_cnt; i++)
			if (!coord_set[i])
				put_coord(3'(i), pick_value());
		drive_beat(OP_EVAL, 4'($urandom), 4'($urandom), 31'($urandom), 3'($urandom),
			31'($urandom));
		beats_sent++;
	endtask

	// Drop valid and wait until every result has drained
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mle_outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_access(input bit wr, input logic idx, input logic [DIM_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
		reg_access(1'b1, REG_NUM_ROWS, rows);
		reg_access(1'b1, REG_NUM_COLS, cols);
		reg_access(1'b0, REG_NUM_ROWS, '0);
		reg_access(1'b0, REG_NUM_COLS, '0);
		eff_rows = (rows == 0) ? 1 : (rows > 16) ? 16 : int'(rows);
		eff_cols = (cols == 0) ? 1 : (cols > 16) ? 16 : int'(cols);
		rb_cnt = 1;
		while ((1 << rb_cnt) < eff_rows)
			rb_cnt++;
		cb_cnt = 1;
		while ((1 << cb_cnt) < eff_cols)
			cb_cnt++;
	endtask

	task automatic random_beat();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			if ($urandom_range(0, 4) != 0)
				put_cell(4'($urandom_range(0, eff_rows - 1)),
					4'($urandom_range(0, eff_cols - 1)), pick_value());
			else
				put_cell(4'($urandom), 4'($urandom), pick_value());
		end else if (pick < 72) begin
			if ($urandom_range(0, 4) != 0)
				put_coord(3'($urandom_range(0, rb_cnt + cb_cnt - 1)), pick_value());
			else
				put_coord(3'($urandom), pick_value());
		end else if (pick < 90) begin
			request_eval();
		end else if (pick < 96) begin
			drive_beat(OP_UNUSED, 4'($urandom), 4'($urandom), 31'($urandom), 3'($urandom),
				31'($urandom));
		end else if (!calm) begin
			settle();
		end
	endtask

	// Hold the result side for a long stretch while evaluations keep coming
	task automatic back_up();
		hold_req = 1500;
		repeat (3) begin
			request_eval();
			repeat (3)
				put_cell(4'($urandom_range(0, eff_rows - 1)),
					4'($urandom_range(0, eff_cols - 1)), pick_value());
		end
		settle();
	endtask

	initial begin : stimulus
		int start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = OP_WRITE_ENTRY;
		row_index = '0;
		col_index = '0;
		entry_value = '0;
		coord_index = '0;
		coord_value = '0;
		calm = 1'b0;
		hold_req = 0;
		beats_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Check reset values, then a 2 x 2 matrix for the directed cases
		reg_access(1'b0, REG_NUM_ROWS, '0);
		reg_access(1'b0, REG_NUM_COLS, '0);
		configure(5'd2, 5'd2);

		// Inputs equal to P fold to zero; corner points pick single cells
		put_cell(4'd0, 4'd0, FIELD_P - 31'd1);
		put_cell(4'd0, 4'd1, FIELD_P);
		put_cell(4'd1, 4'd0, 31'd1);
		put_cell(4'd1, 4'd1, 31'h2AAA_AAAA);
		put_coord(3'd0, 31'd0);
		put_coord(3'd1, FIELD_P);
		request_eval();
		put_coord(3'd0, 31'd1);
		put_coord(3'd1, 31'd1);
		request_eval();
		put_coord(3'd0, FIELD_P - 31'd1);
		put_coord(3'd1, 31'd2);
		request_eval();

		// Unused opcode must leave the state alone
		drive_beat(OP_UNUSED, 4'hF, 4'hF, '1, '1, '1);

		// Writes outside the active area and to the last coordinate
		put_cell(4'd15, 4'd15, 31'h7FFF_FFFE);
		put_coord(3'd7, FIELD_P);
		put_cell(4'd15, 4'd0, 31'd0);
		put_coord(3'd1, 31'h5555_5555);
		request_eval();

		// Random phases over a range of register settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			configure(5'(phase_rows[p]), 5'(phase_cols[p]));
			if (p == NUM_PHASES - 1)
				calm = 1'b1;
			if (p == 3)
				back_up();
			start = beats_sent;
			while (beats_sent - start < PHASE_BEATS)
				random_beat();
			request_eval();
		end

		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && mle_outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
